>>> sv/spc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper position controller package
// Command codes, register indexes, reset values and widths.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SHORT_W = 16;
    localparam int unsigned INDEX_W = 3;

    typedef enum logic [1:0] {
        CMD_STEP     = 2'd0,
        CMD_UPDATE   = 2'd1,
        CMD_SETPOINT = 2'd2
    } cmd_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_DEADBAND      = 3'd0,
        REG_SOFT_LIMIT_ON = 3'd1,
        REG_ENC_CORR_ON   = 3'd2,
        REG_INVERT_DIR    = 3'd3,
        REG_STEPS_PER_RAD = 3'd4,
        REG_LOW_LIMIT     = 3'd5,
        REG_HIGH_LIMIT    = 3'd6,
        REG_STALE_TIMEOUT = 3'd7
    } reg_index_t;

    localparam logic [DATA_W-1:0]  STEPS_PER_RAD_RESET = 32'd2086000;
    localparam logic [DATA_W-1:0]  LOW_LIMIT_RESET     = 32'h8000_0000;
    localparam logic [DATA_W-1:0]  HIGH_LIMIT_RESET    = 32'h7FFF_FFFF;
    localparam logic [SHORT_W-1:0] STALE_TIMEOUT_RESET = 16'd1000;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] angle_mag;
        logic              angle_neg;
        logic [DATA_W-1:0] age_ms;
        logic              fault_line;
        logic [DATA_W-1:0] new_setpoint;
    } in_stage_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [DATA_W-1:0] steps_mag;
        logic              angle_neg;
        logic              stale;
        logic              fault_line;
        logic [DATA_W-1:0] new_setpoint;
    } mul_stage_t;

endpackage : spc_pkg
`default_nettype wire

>>> sv/stepper_position_controller_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stepper position controller
// Pipeline: an accepted request is loaded into the input register at the
// accepting edge, then moves to the gain multiplier register, then to the
// result register, from which its result is reported.
// Throughput: one request per cycle unless in_stall holds the input; the 32x32 gain
// multiply has a stage of its own, and the state update happens in the result stage.
// Reset: asynchronous, active low; state clears, registers take reset values.
// ----------------------------------------------------------------------------
module stepper_position_controller_unit
    import spc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [INDEX_W-1:0]        wr_index,
    input  wire logic [DATA_W-1:0]         wr_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [1:0]                cmd,
    input  wire logic signed [DATA_W-1:0]  encoder_angle,
    input  wire logic [DATA_W-1:0]         encoder_age_ms,
    input  wire logic                      fault_line,
    input  wire logic signed [DATA_W-1:0]  new_setpoint,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [DATA_W-1:0]       position_now,
    output logic                           direction_level,
    output logic                           pulsing,
    output logic                           disable_request,
    output logic                           fault_flag,
    output logic                           on_target
);

    logic [SHORT_W-1:0] deadband_reg;
    logic               soft_limit_on_reg;
    logic               enc_corr_on_reg;
    logic               invert_dir_reg;
    logic [DATA_W-1:0]  steps_per_rad_reg;
    logic [DATA_W-1:0]  low_limit_reg;
    logic [DATA_W-1:0]  high_limit_reg;
    logic [SHORT_W-1:0] stale_timeout_reg;

    logic [DATA_W-1:0]  position_reg, position_next;
    logic [DATA_W-1:0]  target_reg, target_next;
    logic               moving_up_reg, moving_up_next;
    logic               running_reg, running_next;
    logic               fault_reg, fault_next;
    logic               dir_pin_reg, dir_pin_next;

    logic               s1_valid_reg;
    in_stage_t          s1_reg;
    logic               s2_valid_reg;
    mul_stage_t         s2_reg;
    logic               out_valid_reg;
    logic               disable_reg, disable_next;
    logic               on_target_reg, on_target_next;

    logic               s3_ok;
    logic               s2_ok;
    logic               s2_move;
    logic               s1_move;
    logic               accept;
    logic [DATA_W-1:0]  angle_bits;
    logic [2*DATA_W-1:0] product;
    logic [DATA_W-1:0]  conv_steps;
    logic               stale_now;
    logic signed [DATA_W:0] err;
    logic signed [DATA_W:0] db_pos;
    logic signed [DATA_W:0] db_neg;
    logic               on_t;

    assign s3_ok    = !out_valid_reg || !out_stall;
    assign s2_move  = s2_valid_reg && s3_ok;
    assign s2_ok    = !s2_valid_reg || s3_ok;
    assign s1_move  = s1_valid_reg && s2_ok;
    assign in_stall = s1_valid_reg && !s2_ok;
    assign accept   = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg      <= '0;
            soft_limit_on_reg <= 1'b0;
            enc_corr_on_reg   <= 1'b0;
            invert_dir_reg    <= 1'b0;
            steps_per_rad_reg <= STEPS_PER_RAD_RESET;
            low_limit_reg     <= LOW_LIMIT_RESET;
            high_limit_reg    <= HIGH_LIMIT_RESET;
            stale_timeout_reg <= STALE_TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_DEADBAND:      deadband_reg      <= wr_data[SHORT_W-1:0];
                REG_SOFT_LIMIT_ON: soft_limit_on_reg <= wr_data[0];
                REG_ENC_CORR_ON:   enc_corr_on_reg   <= wr_data[0];
                REG_INVERT_DIR:    invert_dir_reg    <= wr_data[0];
                REG_STEPS_PER_RAD: steps_per_rad_reg <= wr_data;
                REG_LOW_LIMIT:     low_limit_reg     <= wr_data;
                REG_HIGH_LIMIT:    high_limit_reg    <= wr_data;
                REG_STALE_TIMEOUT: stale_timeout_reg <= wr_data[SHORT_W-1:0];
                default:           deadband_reg      <= deadband_reg;
            endcase
        end
    end

    // stage 1: capture request, take angle magnitude
    assign angle_bits = encoder_angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.cmd          <= cmd;
            s1_reg.angle_mag    <= angle_bits[DATA_W-1] ? (DATA_W'(0) - angle_bits)
                                                        : angle_bits;
            s1_reg.angle_neg    <= angle_bits[DATA_W-1];
            s1_reg.age_ms       <= encoder_age_ms;
            s1_reg.fault_line   <= fault_line;
            s1_reg.new_setpoint <= new_setpoint;
        end
    end

    // stage 2: gain multiply and freshness check
    assign product   = {{DATA_W{1'b0}}, s1_reg.angle_mag}
                     * {{DATA_W{1'b0}}, steps_per_rad_reg};
    assign stale_now = s1_reg.age_ms > {{(DATA_W-SHORT_W){1'b0}}, stale_timeout_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ok)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_reg.cmd          <= s1_reg.cmd;
            s2_reg.steps_mag    <= product[2*DATA_W-1:DATA_W];
            s2_reg.angle_neg    <= s1_reg.angle_neg;
            s2_reg.stale        <= stale_now;
            s2_reg.fault_line   <= s1_reg.fault_line;
            s2_reg.new_setpoint <= s1_reg.new_setpoint;
        end
    end

    // stage 3: state update and result
    assign conv_steps = s2_reg.angle_neg ? (DATA_W'(0) - s2_reg.steps_mag)
                                         : s2_reg.steps_mag;

    always_comb
    begin
        position_next = position_reg;
        target_next   = target_reg;
        case (cmd_t'(s2_reg.cmd))
            CMD_STEP:
            begin
                position_next = moving_up_reg ? (position_reg + DATA_W'(1))
                                              : (position_reg - DATA_W'(1));
            end
            CMD_UPDATE:
            begin
                if (enc_corr_on_reg && !s2_reg.stale)
                begin
                    position_next = conv_steps;
                end
            end
            CMD_SETPOINT:
            begin
                target_next = s2_reg.new_setpoint;
            end
            default:
            begin
                position_next = position_reg;
            end
        endcase
    end

    assign err    = $signed({position_next[DATA_W-1], position_next})
                  - $signed({target_next[DATA_W-1], target_next});
    assign db_pos = $signed({{(DATA_W+1-SHORT_W){1'b0}}, deadband_reg});
    assign db_neg = -db_pos;
    assign on_t   = (err <= db_pos) && (err >= db_neg);

    always_comb
    begin
        moving_up_next = moving_up_reg;
        running_next   = running_reg;
        fault_next     = fault_reg;
        dir_pin_next   = dir_pin_reg;
        disable_next   = 1'b0;
        case (cmd_t'(s2_reg.cmd))
            CMD_STEP:
            begin
                if (on_t)
                begin
                    running_next = 1'b0;
                end
            end
            CMD_UPDATE:
            begin
                if (enc_corr_on_reg && s2_reg.stale)
                begin
                    fault_next   = 1'b1;
                    disable_next = 1'b1;
                end
                else
                begin
                    fault_next = s2_reg.fault_line;
                    if (!on_t)
                    begin
                        moving_up_next = err[DATA_W];
                        dir_pin_next   = invert_dir_reg ^ !err[DATA_W];
                        running_next   = 1'b1;
                        if (soft_limit_on_reg)
                        begin
                            if ($signed(position_next) > $signed(high_limit_reg)
                                && !err[DATA_W])
                            begin
                                running_next = 1'b0;
                            end
                            if ($signed(position_next) < $signed(low_limit_reg)
                                && err[DATA_W])
                            begin
                                running_next = 1'b0;
                            end
                        end
                    end
                end
            end
            default:
            begin
                running_next = running_reg;
            end
        endcase
    end

    assign on_target_next = on_t;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg  <= '0;
            target_reg    <= '0;
            moving_up_reg <= 1'b0;
            running_reg   <= 1'b0;
            fault_reg     <= 1'b0;
            dir_pin_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= s2_move || (out_valid_reg && out_stall);
            if (s2_move)
            begin
                position_reg  <= position_next;
                target_reg    <= target_next;
                moving_up_reg <= moving_up_next;
                running_reg   <= running_next;
                fault_reg     <= fault_next;
                dir_pin_reg   <= dir_pin_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            disable_reg   <= disable_next;
            on_target_reg <= on_target_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign position_now    = position_reg;
    assign direction_level = dir_pin_reg;
    assign pulsing         = running_reg;
    assign disable_request = disable_reg;
    assign fault_flag      = fault_reg;
    assign on_target       = on_target_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && disable_request |-> fault_flag)
        else $error("disable request without fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        s2_move && (s2_reg.cmd == CMD_STEP) && on_t |=> !running_reg)
        else $error("pulsing continues on target after step");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        !s2_move |=> $stable(position_reg) && $stable(target_reg))
        else $error("state changed without a request");

endmodule : stepper_position_controller_unit
`default_nettype wire

>>> dv/stepper_position_controller_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stepper position controller testbench
// Drives step, update, setpoint and unused-code requests through the valid/stall port
// under several register settings. A behavioral tracker of position, target,
// direction, pulsing and fault predicts every report, and a checker compares
// each accepted report field by field. Both sides idle at random, and one
// long receiver hold-off fills the pipeline until the block stalls its input.
// ----------------------------------------------------------------------------
module stepper_position_controller_unit_tb
    import spc_pkg::*;
();

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int PIPE_LATENCY = 3;
    localparam int LONG_HOLD = 64;
    localparam int TIMEOUT_NS = 3_000_000;

    typedef struct packed {
        logic [DATA_W-1:0] position;
        logic              direction;
        logic              pulsing;
        logic              disable_req;
        logic              fault;
        logic              on_target;
    } motion_report_t;

    logic                      clk;
    logic                      rst_n;
    logic                      wr_en;
    logic [INDEX_W-1:0]        wr_index;
    logic [DATA_W-1:0]         wr_data;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                cmd;
    logic signed [DATA_W-1:0]  encoder_angle;
    logic [DATA_W-1:0]         encoder_age_ms;
    logic                      fault_line;
    logic signed [DATA_W-1:0]  new_setpoint;
    logic                      out_valid;
    logic                      out_stall;
    logic signed [DATA_W-1:0]  position_now;
    logic                      direction_level;
    logic                      pulsing;
    logic                      disable_request;
    logic                      fault_flag;
    logic                      on_target;

    // register copies
    logic [SHORT_W-1:0] deadband_cfg;
    logic               soft_limit_cfg;
    logic               enc_corr_cfg;
    logic               invert_cfg;
    logic [DATA_W-1:0]  gain_cfg;
    logic [DATA_W-1:0]  low_limit_cfg;
    logic [DATA_W-1:0]  high_limit_cfg;
    logic [SHORT_W-1:0] stale_cfg;

    // tracked motion state
    logic [DATA_W-1:0]  track_position;
    logic [DATA_W-1:0]  track_target;
    logic               track_up;
    logic               track_running;
    logic               track_fault;
    logic               track_dir_level;

    motion_report_t expected_reports[$];
    int             mismatch_count = 0;
    int             items_sent = 0;
    int             hold_requests = 0;
    bit             no_idle = 1'b0;
    logic           hold_off = 1'b0;

    stepper_position_controller_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .wr_en           (wr_en),
        .wr_index        (wr_index),
        .wr_data         (wr_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .encoder_angle   (encoder_angle),
        .encoder_age_ms  (encoder_age_ms),
        .fault_line      (fault_line),
        .new_setpoint    (new_setpoint),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .position_now    (position_now),
        .direction_level (direction_level),
        .pulsing         (pulsing),
        .disable_request (disable_request),
        .fault_flag      (fault_flag),
        .on_target       (on_target)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("stepper_position_controller_unit: mismatch");
        $finish;
    end

    function automatic bit within_deadband(input logic [DATA_W-1:0] pos,
                                           input logic [DATA_W-1:0] tgt);
        longint diff;
        diff = longint'($signed(pos)) - longint'($signed(tgt));
        if (diff < 0)
            diff = -diff;
        return diff <= longint'(deadband_cfg);
    endfunction

    function automatic logic [DATA_W-1:0] angle_to_steps(input logic [DATA_W-1:0] angle);
        longint            a;
        longint unsigned   mag;
        longint unsigned   prod;
        logic [DATA_W-1:0] q;
        a = longint'($signed(angle));
        mag = (a < 0) ? -a : a;
        prod = mag * longint'(gain_cfg);
        q = prod[63:32];
        return angle[DATA_W-1] ? -q : q;
    endfunction

    function automatic motion_report_t advance_motion(input logic [1:0] c,
                                                      input logic [DATA_W-1:0] angle,
                                                      input logic [DATA_W-1:0] age,
                                                      input logic flt,
                                                      input logic [DATA_W-1:0] setpoint);
        motion_report_t rep;
        logic           drop_drive;
        drop_drive = 1'b0;
        case (c)
            CMD_STEP:
            begin
                track_position = track_up ? track_position + 1 : track_position - 1;
                if (within_deadband(track_position, track_target))
                    track_running = 1'b0;
            end
            CMD_UPDATE:
            begin
                if (enc_corr_cfg && age > {16'd0, stale_cfg})
                begin
                    drop_drive = 1'b1;
                    track_fault = 1'b1;
                end
                else
                begin
                    if (enc_corr_cfg)
                        track_position = angle_to_steps(angle);
                    track_fault = flt;
                    if (!within_deadband(track_position, track_target))
                    begin
                        track_up = $signed(track_position) < $signed(track_target);
                        track_dir_level = track_up ? invert_cfg : !invert_cfg;
                        if (soft_limit_cfg &&
                            (($signed(track_position) > $signed(high_limit_cfg) && !track_up) ||
                             ($signed(track_position) < $signed(low_limit_cfg) && track_up)))
                            track_running = 1'b0;
                        else
                            track_running = 1'b1;
                    end
                end
            end
            CMD_SETPOINT:
                track_target = setpoint;
            default: ;
        endcase
        rep.position = track_position;
        rep.direction = track_dir_level;
        rep.pulsing = track_running;
        rep.disable_req = drop_drive;
        rep.fault = track_fault;
        rep.on_target = within_deadband(track_position, track_target);
        return rep;
    endfunction

    function automatic logic [DATA_W-1:0] near(input logic [DATA_W-1:0] base,
                                               input int unsigned span);
        return base + $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic logic [DATA_W-1:0] pick_age();
        case ($urandom_range(0, 9))
            0: return {16'd0, stale_cfg} + 32'd1;
            1: return $urandom();
            2: return {16'd0, stale_cfg};
            3: return 32'hFFFF_FFFF;
            default: return $urandom_range(0, stale_cfg);
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [DATA_W-1:0] want,
                                 input logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
    endtask

    task automatic send_request(input logic [1:0] c, input logic [DATA_W-1:0] angle,
                                input logic [DATA_W-1:0] age, input logic flt,
                                input logic [DATA_W-1:0] setpoint);
        bit taken;
        in_valid <= 1'b1;
        cmd <= c;
        encoder_angle <= angle;
        encoder_age_ms <= age;
        fault_line <= flt;
        new_setpoint <= setpoint;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        expected_reports.push_back(advance_motion(c, angle, age, flt, setpoint));
        items_sent++;
        if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_noise();
        send_request(2'($urandom_range(0, 3)), $urandom(), $urandom(),
                     1'($urandom_range(0, 1)), $urandom());
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DEADBAND:      deadband_cfg = value[SHORT_W-1:0];
            REG_SOFT_LIMIT_ON: soft_limit_cfg = value[0];
            REG_ENC_CORR_ON:   enc_corr_cfg = value[0];
            REG_INVERT_DIR:    invert_cfg = value[0];
            REG_STEPS_PER_RAD: gain_cfg = value;
            REG_LOW_LIMIT:     low_limit_cfg = value;
            REG_HIGH_LIMIT:    high_limit_cfg = value;
            REG_STALE_TIMEOUT: stale_cfg = value[SHORT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [SHORT_W-1:0] db, input logic limit_on,
                                  input logic enc, input logic inv,
                                  input logic [DATA_W-1:0] gain,
                                  input logic [DATA_W-1:0] low, input logic [DATA_W-1:0] high,
                                  input logic [SHORT_W-1:0] stale);
        wait_idle();
        write_reg(REG_DEADBAND, {16'd0, db});
        write_reg(REG_SOFT_LIMIT_ON, {31'd0, limit_on});
        write_reg(REG_ENC_CORR_ON, {31'd0, enc});
        write_reg(REG_INVERT_DIR, {31'd0, inv});
        write_reg(REG_STEPS_PER_RAD, gain);
        write_reg(REG_LOW_LIMIT, low);
        write_reg(REG_HIGH_LIMIT, high);
        write_reg(REG_STALE_TIMEOUT, {16'd0, stale});
    endtask

    task automatic run_motion_sequence();
        logic [DATA_W-1:0] angle;
        int                offset;
        int                pulses;
        angle = $urandom_range(0, 1) ? $urandom() : near(32'd0, 32'h0004_0000);
        send_request(CMD_UPDATE, angle, pick_age(), $urandom_range(0, 5) == 0, $urandom());
        offset = $urandom_range(0, 120) - 60;
        send_request(CMD_SETPOINT, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                     track_position + offset);
        send_request(CMD_UPDATE, angle, pick_age(), $urandom_range(0, 7) == 0, $urandom());
        pulses = (offset < 0 ? -offset : offset) + $urandom_range(0, 4);
        repeat (pulses)
        begin
            if ($urandom_range(0, 15) == 0)
                send_noise();
            else
                send_request(CMD_STEP, $urandom(), $urandom(), 1'($urandom_range(0, 1)),
                             $urandom());
        end
    endtask

    task automatic test_reset_defaults();
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd0, 1'b1, 32'd0);
        send_request(CMD_SETPOINT, 32'd0, 32'd0, 1'b0, 32'd3);
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd0, 1'b0, 32'd0);
        repeat (4) send_request(CMD_STEP, 32'd0, 32'd0, 1'b0, 32'd0);
        wait_idle();
        write_reg(REG_ENC_CORR_ON, 32'd1);
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd1000, 1'b0, 32'd0);
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd1001, 1'b0, 32'd0);
    endtask

    task automatic test_encoder_extremes();
        apply_settings(16'hFFFF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF,
                       LOW_LIMIT_RESET, HIGH_LIMIT_RESET, 16'hFFFF);
        send_request(CMD_UPDATE, 32'h8000_0000, 32'h0000_FFFF, 1'b0, 32'd0);
        send_request(CMD_UPDATE, 32'h7FFF_FFFF, 32'd0, 1'b1, 32'd0);
        send_request(CMD_UPDATE, 32'h7FFF_FFFF, 32'h0001_0000, 1'b0, 32'd0);
        send_request(CMD_UPDATE, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'd0);
        wait_idle();
        write_reg(REG_STEPS_PER_RAD, 32'd1);
        send_request(CMD_UPDATE, 32'h7FFF_FFFF, 32'd0, 1'b0, 32'd0);
        send_request(CMD_UPDATE, 32'h8000_0000, 32'd0, 1'b0, 32'd0);
    endtask

    task automatic test_position_wrap();
        apply_settings(16'd0, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF,
                       LOW_LIMIT_RESET, HIGH_LIMIT_RESET, STALE_TIMEOUT_RESET);
        send_request(CMD_UPDATE, 32'h7FFF_FFFF, 32'd5, 1'b0, 32'd0);
        send_request(CMD_SETPOINT, 32'd0, 32'd0, 1'b0, 32'h7FFF_FFFF);
        send_request(CMD_UPDATE, 32'h7FFF_FFFF, 32'd5, 1'b0, 32'd0);
        repeat (2) send_request(CMD_STEP, 32'd0, 32'd0, 1'b0, 32'd0);
        send_request(CMD_SETPOINT, 32'd0, 32'd0, 1'b0, 32'h8000_0000);
        send_request(CMD_UPDATE, 32'h8000_0000, 32'd5, 1'b0, 32'd0);
        repeat (2) send_request(CMD_STEP, 32'd0, 32'd0, 1'b0, 32'd0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    endtask

    task automatic test_stale_timeout();
        apply_settings(16'd0, 1'b0, 1'b1, 1'b0, STEPS_PER_RAD_RESET,
                       LOW_LIMIT_RESET, HIGH_LIMIT_RESET, 16'd1);
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd1, 1'b1, 32'd0);
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd2, 1'b0, 32'd0);
        send_request(CMD_UPDATE, 32'h0001_0000, 32'd0, 1'b0, 32'd0);
    endtask

    task automatic test_soft_limits();
        // limits inverted around the position: both vetoes reachable
        apply_settings(16'd0, 1'b1, 1'b0, 1'b0, STEPS_PER_RAD_RESET,
                       track_position + 10, track_position - 10, STALE_TIMEOUT_RESET);
        send_request(CMD_SETPOINT, 32'd0, 32'd0, 1'b0, track_position - 50);
        send_request(CMD_UPDATE, 32'd0, 32'd0, 1'b0, 32'd0);
        send_request(CMD_SETPOINT, 32'd0, 32'd0, 1'b0, track_position + 50);
        send_request(CMD_UPDATE, 32'd0, 32'd0, 1'b0, 32'd0);
        apply_settings(16'd0, 1'b1, 1'b0, 1'b1, STEPS_PER_RAD_RESET,
                       track_position - 10, track_position + 10, STALE_TIMEOUT_RESET);
        send_request(CMD_UPDATE, 32'd0, 32'd0, 1'b0, 32'd0);
        send_request(CMD_SETPOINT, 32'd0, 32'd0, 1'b0, track_position - 50);
        send_request(CMD_UPDATE, 32'd0, 32'd0, 1'b0, 32'd0);
    endtask

    task automatic test_random_settings();
        int goal;
        logic [DATA_W-1:0] low;
        logic [DATA_W-1:0] high;
        logic [SHORT_W-1:0] db;
        logic [SHORT_W-1:0] stale;
        logic [DATA_W-1:0] gain;
        for (int phase = 0; phase < 6; phase++)
        begin
            db = (phase == 2) ? 16'hFFFF : (phase == 3) ? 16'd0 : 16'($urandom_range(0, 8));
            stale = (phase == 0) ? 16'd1 : (phase == 5) ? 16'hFFFF :
                    16'($urandom_range(1, 16'hFFFF));
            gain = (phase == 3) ? 32'hFFFF_FFFF : (phase == 5) ? 32'd1 :
                   $urandom_range(1, 32'h00FF_FFFF);
            low = near(track_position, 200);
            high = near(track_position, 200);
            if (phase == 1)
            begin
                low = HIGH_LIMIT_RESET;
                high = LOW_LIMIT_RESET;
            end
            apply_settings(db, phase[0], phase != 4, 1'($urandom_range(0, 1)), gain,
                           low, high, stale);
            goal = items_sent + 230;
            while (items_sent < goal)
                run_motion_sequence();
        end
    endtask

    task automatic test_output_hold_off();
        int goal;
        wait_idle();
        no_idle = 1'b1;
        hold_requests <= hold_requests + 1;
        goal = items_sent + 60;
        while (items_sent < goal)
            run_motion_sequence();
        no_idle = 1'b0;
    endtask

    task automatic test_steady_stream();
        int goal;
        apply_settings(16'd2, 1'b1, 1'b1, 1'b0, $urandom_range(1, 32'h0FFF_FFFF),
                       near(track_position, 100), near(track_position, 100), 16'd500);
        no_idle = 1'b1;
        goal = items_sent + 250;
        while (items_sent < goal)
            run_motion_sequence();
    endtask

    // receiver hold-off, counted here so the sender keeps offering
    initial
    begin : receiver_hold_off
        int holds_done;
        holds_done = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                hold_off <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off <= 1'b0;
            end
        end
    end

    initial
    begin : report_backpressure
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_stall <= 1'b1;
            else if (!no_idle && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // values are stable from the falling edge to the accepting rising edge
    always @(negedge clk)
    begin : report_check
        motion_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
                note_mismatch("report with no request", 32'd0, position_now);
            else
            begin
                want = expected_reports.pop_front();
                if (position_now !== want.position)
                    note_mismatch("position_now", want.position, position_now);
                if (direction_level !== want.direction)
                    note_mismatch("direction_level", want.direction, direction_level);
                if (pulsing !== want.pulsing)
                    note_mismatch("pulsing", want.pulsing, pulsing);
                if (disable_request !== want.disable_req)
                    note_mismatch("disable_request", want.disable_req, disable_request);
                if (fault_flag !== want.fault)
                    note_mismatch("fault_flag", want.fault, fault_flag);
                if (on_target !== want.on_target)
                    note_mismatch("on_target", want.on_target, on_target);
            end
        end
    end

    initial
    begin : main_sequence
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 1'b0;
        cmd = CMD_STEP;
        encoder_angle = '0;
        encoder_age_ms = '0;
        fault_line = 1'b0;
        new_setpoint = '0;
        deadband_cfg = '0;
        soft_limit_cfg = 1'b0;
        enc_corr_cfg = 1'b0;
        invert_cfg = 1'b0;
        gain_cfg = STEPS_PER_RAD_RESET;
        low_limit_cfg = LOW_LIMIT_RESET;
        high_limit_cfg = HIGH_LIMIT_RESET;
        stale_cfg = STALE_TIMEOUT_RESET;
        track_position = '0;
        track_target = '0;
        track_up = 1'b0;
        track_running = 1'b0;
        track_fault = 1'b0;
        track_dir_level = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_encoder_extremes();
        test_position_wrap();
        test_stale_timeout();
        test_soft_limits();
        test_random_settings();
        test_output_hold_off();
        test_steady_stream();
        wait_idle();
        repeat (10) @(posedge clk);

        if (mismatch_count == 0 && expected_reports.size() == 0)
            $display("stepper_position_controller_unit: match");
        else
            $display("stepper_position_controller_unit: mismatch");
        $finish;
    end

endmodule
